/* rtl/core/sssp_pkg.sv */
// Shared types and constants for the shortest path engine.
// No dependencies.
`default_nettype none
package sssp_pkg;
   localparam int NODES_DEF = 64;
   localparam int EDGES_DEF = 256;
   localparam logic [19:0] UNREACHED = 20'd1000001;
   localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_SCAN, ST_SCAN_WAIT, ST_SCAN_END, ST_SWEEP, ST_SWEEP_END,
      ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic do_clear;
      logic do_add;
      logic start;     // latch source, reset counter
      logic init_step; // write one node's init entry
      logic scan_step;
      logic scan_end;  // settle chosen node
      logic sweep_step;
      logic emit_load;
      logic emit_next;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic idx_last;   // node counter at n-1
      logic edge_last;  // edge counter at last loaded edge
      logic no_edges;
      logic best_none;  // nothing left to settle
      logic src_bad;
      logic pipe_busy;  // sweep pipeline still holds writes
   } stat_type;
endpackage
`default_nettype wire

/* rtl/core/sssp_ram.sv */
// Generic single-port write, single read RAM with registered read.
// No dependencies.
`default_nettype none
module sssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/sssp_ctrl.sv */
// Sequencer for load, run and emit phases.
// Uses sssp_pkg.
`default_nettype none
module sssp_ctrl
   import sssp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire stat_type   stat,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic acc;
   assign acc = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (acc && req_action == ACT_RUN) state_in = ST_INIT;
         ST_INIT:
            if (stat.idx_last) state_in = stat.src_bad ? ST_EMIT_RD : ST_SCAN;
         ST_SCAN:
            if (stat.idx_last) state_in = ST_SCAN_WAIT;
         // last node word comes out of the RAM here
         ST_SCAN_WAIT: state_in = ST_SCAN_END;
         ST_SCAN_END:
            if (stat.best_none) state_in = ST_EMIT_RD;
            else if (stat.no_edges) state_in = ST_SWEEP_END;
            else state_in = ST_SWEEP;
         ST_SWEEP:
            if (stat.edge_last) state_in = ST_SWEEP_END;
         ST_SWEEP_END:
            if (!stat.pipe_busy) state_in = ST_SCAN;
         ST_EMIT_RD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: state_in = ST_EMIT;
         ST_EMIT:
            if (rsp_ready) state_in = stat.idx_last ? ST_IDLE : ST_EMIT_RD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.do_clear = acc && req_action == ACT_CLEAR;
            cmd.do_add = acc && req_action == ACT_ADD;
            cmd.start = acc && req_action == ACT_RUN;
         end
         ST_INIT: cmd.init_step = 1'b1;
         ST_SCAN: cmd.scan_step = 1'b1;
         ST_SCAN_WAIT: ;
         ST_SCAN_END: cmd.scan_end = 1'b1;
         ST_SWEEP: cmd.sweep_step = 1'b1;
         ST_SWEEP_END: ;
         ST_EMIT_RD: ;
         ST_EMIT_WAIT: cmd.emit_load = 1'b1;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit_next = rsp_ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

/* rtl/core/sssp_dp.sv */
// Datapath: edge store, node table, min scan and relaxation pipeline.
// Uses sssp_pkg and sssp_ram.
`default_nettype none
module sssp_dp
   import sssp_pkg::*;
#(
   parameter int NODES = NODES_DEF,
   parameter int EDGES = EDGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [6:0]  node_count,
   input  wire logic [5:0]  edge_from,
   input  wire logic [5:0]  edge_to,
   input  wire logic [13:0] edge_weight,
   input  wire logic [5:0]  source_node,
   output logic [5:0]       node,
   output logic [19:0]      distance,
   output logic [5:0]       parent,
   output logic             has_parent,
   output logic             edge_overflow,
   output logic             last
);
   localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;
   localparam int CW = $clog2(EDGES + 1);
   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   // node word: settled, has parent, parent, distance
   localparam int NWW = 28;

   // effective node count
   logic [6:0] n_eff;
   always_comb begin
      if (node_count == 7'd0) n_eff = 7'd1;
      else if (node_count > 7'(NODES)) n_eff = 7'(NODES);
      else n_eff = node_count;
   end

   logic [CW-1:0] loaded_ff;
   logic ovf_ff;
   logic [12:0] mag;
   logic [13:0] neg;
   assign neg = 14'd0 - edge_weight;
   assign mag = edge_weight[13] ? ((neg[13]) ? 13'h1FFF : neg[12:0]) : edge_weight[12:0];
   logic add_ok;
   assign add_ok = (loaded_ff < CW'(EDGES)) && ({1'b0, edge_from} < n_eff)
                   && ({1'b0, edge_to} < n_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.do_clear) begin
         loaded_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.do_add) begin
         if (add_ok) loaded_ff <= loaded_ff + CW'(1);
         else ovf_ff <= 1'b1;
      end
   end

   // edge store: tail, head, cost in one word
   logic [EW-1:0] e_ff;
   logic [24:0] e_rd;
   sssp_ram #(.WIDTH(25), .DEPTH(EDGES)) u_edges (
      .clock(clock), .wr_en(cmd.do_add && add_ok), .wr_addr(loaded_ff[EW-1:0]),
      .wr_data({edge_from, edge_to, mag}), .rd_addr(e_ff), .rd_data(e_rd));

   logic [NW-1:0] i_ff;
   logic [5:0] src_ff;
   logic [NW-1:0] best_ff;
   logic best_ok_ff;
   logic [19:0] bdist_ff;
   logic [5:0] bpar_ff;
   logic bhp_ff;

   // scan: node word for ri_ff arrives in the cycle after its read
   logic sv_ff;
   logic [NW-1:0] ri_ff;

   // sweep pipeline: stage 1 = edge word valid, stage 2 = node word valid
   logic s1_ff, s2_ff;
   logic [5:0] h2_ff;
   logic [19:0] cand2_ff;
   logic fwd_ok_ff;
   logic [NW-1:0] fwd_h_ff;
   logic [NWW-1:0] fwd_word_ff;

   // node table
   logic n_we;
   logic [NW-1:0] n_wr_addr;
   logic [NW-1:0] n_rd_addr;
   logic [NWW-1:0] n_wr_data;
   logic [NWW-1:0] n_rd;
   sssp_ram #(.WIDTH(NWW), .DEPTH(NODES)) u_nodes (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wr_addr), .wr_data(n_wr_data),
      .rd_addr(n_rd_addr), .rd_data(n_rd));

   assign stat.idx_last = (7'(i_ff) == n_eff - 7'd1);
   assign stat.edge_last = (CW'(e_ff) == loaded_ff - CW'(1));
   assign stat.no_edges = (loaded_ff == '0);
   assign stat.best_none = !best_ok_ff || bdist_ff >= UNREACHED;
   assign stat.src_bad = ({1'b0, src_ff} >= n_eff);
   assign stat.pipe_busy = s1_ff || s2_ff;

   logic [NW-1:0] src_idx;
   assign src_idx = src_ff[NW-1:0];

   // a relax write in the previous cycle is not yet seen by the RAM read
   logic [NWW-1:0] cur_word;
   logic relax_hit;
   assign cur_word = (fwd_ok_ff && fwd_h_ff == h2_ff[NW-1:0]) ? fwd_word_ff : n_rd;
   assign relax_hit = s2_ff && (cur_word[19:0] > cand2_ff);

   assign n_rd_addr = s1_ff ? e_rd[13 +: NW] : i_ff;

   always_comb begin
      n_we = 1'b0;
      n_wr_addr = i_ff;
      n_wr_data = '0;
      if (cmd.init_step) begin
         n_we = 1'b1;
         n_wr_data = {1'b0, 1'b0, 6'd0,
                      (i_ff == src_idx && !stat.src_bad) ? 20'd0 : UNREACHED};
      end else if (cmd.scan_end && !stat.best_none) begin
         n_we = 1'b1;
         n_wr_addr = best_ff;
         n_wr_data = {1'b1, bhp_ff, bpar_ff, bdist_ff};
      end else if (relax_hit) begin
         n_we = 1'b1;
         n_wr_addr = h2_ff[NW-1:0];
         n_wr_data = {cur_word[27], 1'b1, 6'(best_ff), cand2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         sv_ff <= 1'b0;
         fwd_ok_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.sweep_step;
         s2_ff <= s1_ff && e_rd[24:19] == 6'(best_ff)
                  && ({1'b0, e_rd[18:13]} < n_eff);
         sv_ff <= cmd.scan_step;
         fwd_ok_ff <= relax_hit;
      end
   end

   always_ff @(posedge clock) begin
      h2_ff <= e_rd[18:13];
      cand2_ff <= bdist_ff + 20'(e_rd[12:0]);
      ri_ff <= i_ff;
      fwd_h_ff <= n_wr_addr;
      fwd_word_ff <= n_wr_data;

      if (cmd.start) begin
         src_ff <= source_node;
         i_ff <= '0;
      end
      if (cmd.init_step) begin
         i_ff <= stat.idx_last ? '0 : i_ff + NW'(1);
         best_ok_ff <= 1'b0;
      end
      if (cmd.scan_step) begin
         i_ff <= stat.idx_last ? '0 : i_ff + NW'(1);
         e_ff <= '0;
      end
      if (sv_ff && !n_rd[27] && (!best_ok_ff || n_rd[19:0] < bdist_ff)) begin
         best_ff <= ri_ff;
         bdist_ff <= n_rd[19:0];
         bpar_ff <= n_rd[25:20];
         bhp_ff <= n_rd[26];
         best_ok_ff <= 1'b1;
      end
      // next scan starts fresh
      if (cmd.scan_end) begin
         best_ok_ff <= 1'b0;
         i_ff <= '0;
      end
      if (cmd.sweep_step) e_ff <= e_ff + EW'(1);
      if (cmd.emit_load) begin
         node <= 6'(i_ff);
         distance <= n_rd[19:0];
         parent <= n_rd[26] ? n_rd[25:20] : 6'd0;
         has_parent <= n_rd[26];
         edge_overflow <= ovf_ff;
         last <= stat.idx_last;
      end
      if (cmd.emit_next) i_ff <= stat.idx_last ? '0 : i_ff + NW'(1);
   end
endmodule
`default_nettype wire

/* rtl/core/single_source_shortest_path.sv */
// Top level of the shortest path engine: controller plus datapath.
// Uses sssp_pkg, sssp_ctrl, sssp_dp, sssp_ram.
//
// Input words (req_*) carry an action: clear edge store, add edge, or run.
// Clear, add and the unused action give no result. A run initializes
// the n node entries and, for a source below n, then per settled node
// scans all n nodes through the node RAM's registered read and sweeps
// the E stored edges through a two-stage relax pipeline (the sweep is
// skipped when the store is empty); its pace is bounded by the two RAM
// read ports. It then sends n result words (rsp_*), in node order,
// reading the next word only after the current one is taken. A stalled
// receiver holds the current word; no new input is taken until the last
// result is delivered.
// csr_wr_en writes node_count; write it only while the block is idle.
// Reset empties the edge store and sets node_count to 64; every run
// rewrites the node entries, so no clearing pass is needed.
`default_nettype none
module single_source_shortest_path
   import sssp_pkg::*;
#(
   parameter int NODES = NODES_DEF,
   parameter int EDGES = EDGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [5:0]  req_edge_from,
   input  wire logic [5:0]  req_edge_to,
   input  wire logic signed [13:0] req_edge_weight,
   input  wire logic [5:0]  req_source_node,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_node,
   output logic [19:0]      rsp_distance,
   output logic [5:0]       rsp_parent,
   output logic             rsp_has_parent,
   output logic             rsp_edge_overflow,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);
   cmd_type cmd;
   stat_type stat;
   logic [6:0] node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= NODE_COUNT_RESET;
      else if (csr_wr_en) node_count_ff <= csr_wr_data;
   end

   sssp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .cmd(cmd));

   sssp_dp #(.NODES(NODES), .EDGES(EDGES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .node_count(node_count_ff), .edge_from(req_edge_from), .edge_to(req_edge_to),
      .edge_weight(req_edge_weight), .source_node(req_source_node),
      .node(rsp_node), .distance(rsp_distance), .parent(rsp_parent),
      .has_parent(rsp_has_parent), .edge_overflow(rsp_edge_overflow),
      .last(rsp_last));

   a_no_ready_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken during emit");
   a_parent_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_parent) |-> rsp_parent == 6'd0)
      else $error("parent without flag");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("not idle after last word");
endmodule
`default_nettype wire

/* tb/sv/single_source_shortest_path_tb.sv */
// Self-checking bench for single_source_shortest_path: predicts every result word
// of each run with its own shortest path search and compares every field.
// Depends on sssp_pkg and the single_source_shortest_path RTL.
`default_nettype none
module single_source_shortest_path_tb;
   import sssp_pkg::*;

   typedef struct packed {
      action_type  action;
      logic [5:0]  edge_from;
      logic [5:0]  edge_to;
      logic [13:0] edge_weight;
      logic [5:0]  source_node;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  node;
      logic [19:0] distance;
      logic [5:0]  parent;
      logic        has_parent;
      logic        edge_overflow;
      logic        last;
   } rsp_word_type;

   // a queue entry is either a request word or a node_count write
   typedef struct packed {
      logic         is_cfg;
      logic [6:0]   cfg_value;
      logic         wait_drain;
      req_word_type word;
   } stim_type;

   localparam int MAX_CYCLES = 5000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = '0;
   logic [5:0] req_edge_from = '0;
   logic [5:0] req_edge_to = '0;
   logic signed [13:0] req_edge_weight = '0;
   logic [5:0] req_source_node = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_node;
   logic [19:0] rsp_distance;
   logic [5:0] rsp_parent;
   logic rsp_has_parent, rsp_edge_overflow, rsp_last;
   logic csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = '0;

   single_source_shortest_path uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_edge_from(req_edge_from),
      .req_edge_to(req_edge_to), .req_edge_weight(req_edge_weight),
      .req_source_node(req_source_node),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_node(rsp_node), .rsp_distance(rsp_distance),
      .rsp_parent(rsp_parent), .rsp_has_parent(rsp_has_parent),
      .rsp_edge_overflow(rsp_edge_overflow), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   logic [5:0]  graph_tail [EDGES_DEF];
   logic [5:0]  graph_head [EDGES_DEF];
   logic [12:0] graph_cost [EDGES_DEF];
   int          graph_edges = 0;
   logic        graph_dropped = 1'b0;
   logic [6:0]  node_count_reg = NODE_COUNT_RESET;

   stim_type     pending_words [$];
   rsp_word_type expected_paths [$];
   int mismatches = 0;
   int words_seen = 0;
   int cycle_count = 0;
   bit quiet_idle = 1'b0;
   bit stim_done = 1'b0;

   function automatic void queue_stim(stim_type x);
      pending_words = {pending_words, x};
   endfunction

   function automatic int live_nodes();
      if (node_count_reg == 0) return 1;
      if (node_count_reg > NODES_DEF) return NODES_DEF;
      return node_count_reg;
   endfunction

   function automatic logic [12:0] weight_magnitude(logic [13:0] w);
      logic [13:0] m;
      m = w[13] ? (14'd0 - w) : w;
      return (m > 14'd8191) ? 13'd8191 : m[12:0];
   endfunction

   task automatic predict_word(req_word_type w);
      int n, best, round;
      logic [19:0]  node_dist [NODES_DEF];
      logic [6:0]   par [NODES_DEF];
      bit           done [NODES_DEF];
      logic [19:0]  cand;
      rsp_word_type r;
      n = live_nodes();
      case (w.action)
         ACT_CLEAR: begin
            graph_edges = 0;
            graph_dropped = 1'b0;
         end
         ACT_ADD: begin
            if (graph_edges >= EDGES_DEF || w.edge_from >= n || w.edge_to >= n)
               graph_dropped = 1'b1;
            else begin
               graph_tail[graph_edges] = w.edge_from;
               graph_head[graph_edges] = w.edge_to;
               graph_cost[graph_edges] = weight_magnitude(w.edge_weight);
               graph_edges++;
            end
         end
         ACT_RUN: begin
            for (int i = 0; i < n; i++) begin
               node_dist[i] = UNREACHED;
               par[i] = 7'h40;
               done[i] = 1'b0;
            end
            if (w.source_node < n) begin
               node_dist[w.source_node] = 20'd0;
               for (round = 0; round < n; round++) begin
                  best = n;
                  for (int i = 0; i < n; i++)
                     if (!done[i] && (best == n || node_dist[i] < node_dist[best]))
                        best = i;
                  if (best == n || node_dist[best] >= UNREACHED) break;
                  done[best] = 1'b1;
                  for (int e = 0; e < graph_edges; e++) begin
                     if (graph_tail[e] != best || graph_head[e] >= n) continue;
                     cand = node_dist[best] + 20'(graph_cost[e]);
                     if (node_dist[graph_head[e]] > cand) begin
                        node_dist[graph_head[e]] = cand;
                        par[graph_head[e]] = 7'(best);
                     end
                  end
               end
            end
            for (int i = 0; i < n; i++) begin
               r.node = 6'(i);
               r.distance = node_dist[i];
               r.has_parent = (par[i] != 7'h40);
               r.parent = r.has_parent ? par[i][5:0] : 6'd0;
               r.edge_overflow = graph_dropped;
               r.last = (i == n - 1);
               expected_paths = {expected_paths, r};
            end
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      stim_type head;
      bit fire, load, cfg_now;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         fire = req_valid && req_ready;
         load = 1'b0;
         cfg_now = 1'b0;
         if (fire) begin
            head = pending_words.pop_front();
            predict_word(head.word);
         end
         if (!req_valid || fire) begin
            if (pending_words.size() > 0) begin
               if (pending_words[0].is_cfg || pending_words[0].wait_drain) begin
                  // hold off until the engine has delivered everything
                  if (!fire && expected_paths.size() == 0 && req_ready) begin
                     if (pending_words[0].is_cfg) begin
                        cfg_now = 1'b1;
                        csr_wr_data <= pending_words[0].cfg_value;
                        node_count_reg <= pending_words[0].cfg_value;
                        void'(pending_words.pop_front());
                     end else
                        pending_words[0].wait_drain = 1'b0;
                  end
               end else if (quiet_idle || $urandom_range(99) >= 10) begin
                  load = 1'b1;
                  req_action <= pending_words[0].word.action;
                  req_edge_from <= pending_words[0].word.edge_from;
                  req_edge_to <= pending_words[0].word.edge_to;
                  req_edge_weight <= pending_words[0].word.edge_weight;
                  req_source_node <= pending_words[0].word.source_node;
               end
            end
            req_valid <= load;
         end
         csr_wr_en <= cfg_now;
         stim_done <= (pending_words.size() == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset) begin
         rsp_ready <= quiet_idle || $urandom_range(99) >= 10;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_node, rsp_distance, rsp_parent, rsp_has_parent,
                    rsp_edge_overflow, rsp_last};
            words_seen++;
            if (expected_paths.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word node %0d", got.node);
            end else begin
               want = expected_paths.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp node %0d dist %0d par %0d hp %0d ovf %0d last %0d",
                        want.node, want.distance, want.parent, want.has_parent,
                        want.edge_overflow, want.last);
                     $display("          got node %0d dist %0d par %0d hp %0d ovf %0d last %0d",
                        got.node, got.distance, got.parent, got.has_parent,
                        got.edge_overflow, got.last);
                  end
               end
            end
         end
      end
   end

   function automatic stim_type mk(action_type a, int f, int t, int w, int s);
      stim_type x;
      x = '0;
      x.word.action = a;
      x.word.edge_from = 6'(f);
      x.word.edge_to = 6'(t);
      x.word.edge_weight = 14'(w);
      x.word.source_node = 6'(s);
      return x;
   endfunction

   function automatic stim_type mk_cfg(int v);
      stim_type x;
      x = '0;
      x.is_cfg = 1'b1;
      x.cfg_value = 7'(v);
      return x;
   endfunction

   function automatic stim_type rand_word(int n);
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return mk(ACT_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                   $urandom_range(16383), 0);
      if (r < 78)
         return mk(ACT_ADD, $urandom_range(63), $urandom_range(63), $urandom, 0);
      if (r < 88) return mk(ACT_RUN, 0, 0, 0, $urandom_range(n - 1));
      if (r < 91) return mk(ACT_RUN, 0, 0, 0, $urandom_range(63));
      if (r < 95) return mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
      return mk(ACT_NONE, $urandom, $urandom, $urandom, $urandom);
   endfunction

   initial begin
      int n;
      int sizes [6];
      stim_type d;
      sizes = '{6, 1, 0, 12, 127, 3};
      // directed: extremes of weights, each action, lowered count, bad source
      queue_stim(mk(ACT_RUN, 0, 0, 0, 63));
      queue_stim(mk(ACT_ADD, 0, 63, -8192, 0));
      queue_stim(mk(ACT_ADD, 63, 1, 8191, 0));
      queue_stim(mk(ACT_ADD, 0, 1, -1, 0));
      queue_stim(mk(ACT_ADD, 1, 2, 0, 0));
      queue_stim(mk(ACT_ADD, 0, 2, 1, 0));
      queue_stim(mk(ACT_ADD, 2, 0, 5, 0));
      queue_stim(mk(ACT_NONE, 63, 63, -1, 63));
      queue_stim(mk(ACT_RUN, 0, 0, 0, 0));
      queue_stim(mk_cfg(4));
      queue_stim(mk(ACT_ADD, 4, 0, 3, 0));
      queue_stim(mk(ACT_ADD, 3, 3, 2, 0));
      queue_stim(mk(ACT_RUN, 0, 0, 0, 0));
      queue_stim(mk(ACT_RUN, 0, 0, 0, 4));
      queue_stim(mk(ACT_CLEAR, 0, 0, 0, 0));
      queue_stim(mk(ACT_RUN, 0, 0, 0, 3));
      queue_stim(mk_cfg(1));
      queue_stim(mk(ACT_ADD, 0, 0, 7, 0));
      queue_stim(mk(ACT_RUN, 0, 0, 0, 0));
      // random phases over several node counts
      foreach (sizes[p]) begin
         queue_stim(mk_cfg(sizes[p]));
         n = (sizes[p] == 0) ? 1 : (sizes[p] > 64 ? 64 : sizes[p]);
         for (int i = 0; i < 13; i++) begin
            d = rand_word(n);
            if (i == 6) d.wait_drain = 1'b1;
            queue_stim(d);
         end
         queue_stim(mk(ACT_RUN, 0, 0, 0, $urandom_range(n - 1)));
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (3000) @(posedge clock);
      quiet_idle = 1'b1;
      repeat (20000) @(posedge clock);
      quiet_idle = 1'b0;
   end

   initial begin
      wait (stim_done && expected_paths.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered clears, adds with dropped edges, idle actions, runs over node counts 1 to 64");
      $display("result words checked: %0d, mismatches: %0d", words_seen, mismatches);
      if (mismatches == 0 && expected_paths.size() == 0)
         $display("single_source_shortest_path verification clean");
      else
         $display("single_source_shortest_path verification failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= MAX_CYCLES);
      $display("timeout after %0d cycles", cycle_count);
      $display("single_source_shortest_path verification failed");
      $finish;
   end
endmodule
`default_nettype wire

/* single_source_shortest_path.f */
rtl/core/sssp_pkg.sv
rtl/core/sssp_ram.sv
rtl/core/sssp_ctrl.sv
rtl/core/sssp_dp.sv
rtl/core/single_source_shortest_path.sv
tb/sv/single_source_shortest_path_tb.sv
